[rtl/psta_pkg.sv]
`default_nettype none
package psta_pkg;

  localparam int NUM_SLOTS_DEF     = 32768;
  localparam int POOL_PAGES_DEF    = 8192;
  localparam int MATERIAL_BITS_DEF = 12;

  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 15;
  localparam int MATIN_W  = 12;
  localparam int TICK_W   = 32;
  localparam int STATUS_W = 2;
  localparam int PAGE_W   = 13;
  localparam int CNT_W    = 14;
  localparam int DELAY_W  = 16;

  localparam logic [DELAY_W-1:0] DELAY_RST = 16'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENSURE  = 2'd0,
    KIND_SETSENT = 2'd1,
    KIND_DEMOTE  = 2'd2,
    KIND_TICK    = 2'd3
  } kind_t;

  localparam logic [STATUS_W-1:0] ST_CHANGED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOCHANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

  // classified request passed from front to back
  typedef struct packed {
    kind_t               kind;
    logic                slot_ok;
    logic [SLOT_W-1:0]   slot;
    logic [MATIN_W-1:0]  material;
    logic [TICK_W-1:0]   tick;
  } req_t;

endpackage
`default_nettype wire

[rtl/psta_front.sv]
`default_nettype none
module psta_front #(
  parameter int NUM_SLOTS     = psta_pkg::NUM_SLOTS_DEF,
  parameter int MATERIAL_BITS = psta_pkg::MATERIAL_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [psta_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [psta_pkg::SLOT_W-1:0]   in_slot,
  input  wire logic [psta_pkg::MATIN_W-1:0]  in_material,
  input  wire logic [psta_pkg::TICK_W-1:0]   in_tick,
  output logic                               q_valid,
  input  wire logic                          q_pop,
  output psta_pkg::req_t                     q_req
);

  // two-entry queue between classifier and executor
  psta_pkg::req_t    mem_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  psta_pkg::req_t    req;
  logic [psta_pkg::MATIN_W-1:0] mmask;
  logic              push;

  assign mmask = psta_pkg::MATIN_W'((1 << MATERIAL_BITS) - 1);

  // classify: range check the slot and mask the material
  always_comb begin
    req.kind     = psta_pkg::kind_t'(in_kind);
    req.slot_ok  = (32'(in_slot) < NUM_SLOTS);
    req.slot     = in_slot;
    req.material = in_material & mmask;
    req.tick     = in_tick;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= req;
    end
  end

endmodule
`default_nettype wire

[rtl/psta_back.sv]
`default_nettype none
module psta_back #(
  parameter int NUM_SLOTS     = psta_pkg::NUM_SLOTS_DEF,
  parameter int POOL_PAGES    = psta_pkg::POOL_PAGES_DEF,
  parameter int MATERIAL_BITS = psta_pkg::MATERIAL_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [psta_pkg::DELAY_W-1:0]    cfg_wdata,
  input  wire logic                            q_valid,
  output logic                                 q_pop,
  input  psta_pkg::req_t                       q_req,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [psta_pkg::STATUS_W-1:0]        out_status,
  output logic [psta_pkg::PAGE_W-1:0]          out_page,
  output logic                                 out_fill_needed,
  output logic [psta_pkg::MATIN_W-1:0]         out_fill_material,
  output logic [psta_pkg::CNT_W-1:0]           out_retired_count,
  output logic [psta_pkg::CNT_W-1:0]           out_pages_in_use,
  output logic [psta_pkg::CNT_W-1:0]           out_pages_high_water
);

  localparam int SA  = (NUM_SLOTS  > 1) ? $clog2(NUM_SLOTS)  : 1;
  localparam int PA  = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int PCW = $clog2(POOL_PAGES + 1);
  localparam int PGW = psta_pkg::PAGE_W;
  localparam int MW  = psta_pkg::MATIN_W;
  localparam int TW  = psta_pkg::TICK_W;
  // entry: {sentinel flag, page or material}
  localparam int EW  = 1 + ((PGW > MW) ? PGW : MW);
  localparam logic [PCW-1:0] POOL_N = PCW'(POOL_PAGES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_EXEC, S_RET_RD, S_RET_CHK, S_OUT
  } state_t;

  // memories
  logic [EW-1:0]       slot_mem [NUM_SLOTS];
  logic [PGW-1:0]      stk_mem  [POOL_PAGES];
  logic [PGW+TW-1:0]   ret_mem  [POOL_PAGES];

  state_t              st_r;
  logic [SA:0]         clr_r;
  logic [EW-1:0]       ent_r;
  logic [PGW-1:0]      stk_q_r;
  logic [PGW+TW-1:0]   ret_q_r;
  logic [PCW-1:0]      free_cnt_r;
  logic [PCW-1:0]      stk_low_r;    // lowest fill reached; entries from here up were rewritten
  logic [PA-1:0]       ret_head_r;
  logic [PCW-1:0]      ret_fill_r;
  logic [psta_pkg::CNT_W-1:0] in_use_r, hw_r, retired_r;
  logic [psta_pkg::DELAY_W-1:0] delay_r;
  psta_pkg::req_t      req_r;

  logic                resident;
  logic [PGW-1:0]      ent_page;
  logic [MW-1:0]       ent_mat;
  logic [EW-1:0]       new_sent;
  logic [PGW-1:0]      pop_page;
  logic [PCW:0]        ret_sum;
  logic [PA-1:0]       ret_tail;
  logic [TW-1:0]       age;

  assign resident = ~ent_r[EW-1];
  assign ent_page = ent_r[PGW-1:0];
  assign ent_mat  = ent_r[MW-1:0];
  assign new_sent = {1'b1, (EW-1)'(req_r.material)};
  // a never-pushed stack slot yields its implicit page, POOL_N minus the free count
  assign pop_page = ((free_cnt_r - 1'b1) >= stk_low_r) ? stk_q_r :
                    PGW'(POOL_N - free_cnt_r);
  // wrap the tail index at the pool size
  assign ret_sum  = (PCW+1)'(ret_head_r) + (PCW+1)'(ret_fill_r);
  assign ret_tail = (ret_sum >= (PCW+1)'(POOL_PAGES)) ?
                    PA'(ret_sum - (PCW+1)'(POOL_PAGES)) : PA'(ret_sum);
  assign age      = req_r.tick - ret_q_r[TW-1:0];
  assign q_pop    = (st_r == S_IDLE) && q_valid;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= psta_pkg::DELAY_RST;
    end else if (cfg_we) begin
      delay_r <= cfg_wdata;
    end
  end

  // memory reads, one per memory per cycle
  always_ff @(posedge clk) begin
    ent_r   <= slot_mem[req_r.slot[SA-1:0]];
    stk_q_r <= stk_mem[PA'(free_cnt_r - 1'b1)];
    ret_q_r <= ret_mem[ret_head_r];
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (st_r == S_CLEAR) begin
      slot_mem[clr_r[SA-1:0]] <= {1'b1, (EW-1)'(0)};
    end else if (st_r == S_EXEC && req_r.slot_ok) begin
      case (req_r.kind)
        psta_pkg::KIND_ENSURE: begin
          if (!resident && free_cnt_r != '0) begin
            slot_mem[req_r.slot[SA-1:0]] <= {1'b0, (EW-1)'(pop_page)};
          end
        end
        psta_pkg::KIND_SETSENT: begin
          if (ent_r != new_sent) begin
            slot_mem[req_r.slot[SA-1:0]] <= new_sent;
          end
        end
        psta_pkg::KIND_DEMOTE: begin
          if (resident) begin
            slot_mem[req_r.slot[SA-1:0]] <= {1'b1, (EW-1)'(0)};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_EXEC && req_r.slot_ok && req_r.kind == psta_pkg::KIND_SETSENT &&
        ent_r != new_sent && resident && free_cnt_r < POOL_N) begin
      stk_mem[PA'(free_cnt_r)] <= ent_page;
    end else if (st_r == S_RET_CHK && age >= TW'(delay_r) && free_cnt_r < POOL_N) begin
      stk_mem[PA'(free_cnt_r)] <= ret_q_r[TW+PGW-1:TW];
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_EXEC && req_r.slot_ok && req_r.kind == psta_pkg::KIND_DEMOTE &&
        resident && ret_fill_r < POOL_N) begin
      ret_mem[ret_tail] <= {ent_page, req_r.tick};
    end
  end

  // sequencer with state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_CLEAR;
      clr_r      <= '0;
      free_cnt_r <= POOL_N;
      stk_low_r  <= POOL_N;
      ret_head_r <= '0;
      ret_fill_r <= '0;
      in_use_r   <= '0;
      hw_r       <= '0;
      retired_r  <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (SA+1)'(NUM_SLOTS - 1)) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            req_r     <= q_req;
            retired_r <= '0;
            st_r      <= (q_req.kind == psta_pkg::KIND_TICK) ? S_RET_RD : S_RD;
          end
        end
        S_RD: begin
          st_r <= S_EXEC;
        end
        S_EXEC: begin
          out_status        <= psta_pkg::ST_NOCHANGE;
          out_page          <= '0;
          out_fill_needed   <= 1'b0;
          out_fill_material <= '0;
          out_retired_count <= '0;
          out_pages_in_use  <= in_use_r;
          out_pages_high_water <= hw_r;
          if (req_r.slot_ok) begin
            case (req_r.kind)
              psta_pkg::KIND_ENSURE: begin
                if (resident) begin
                  out_page <= ent_page;
                end else if (free_cnt_r == '0) begin
                  out_status <= psta_pkg::ST_EXHAUSTED;
                end else begin
                  free_cnt_r        <= free_cnt_r - 1'b1;
                  if (free_cnt_r == stk_low_r) begin
                    stk_low_r <= free_cnt_r - 1'b1;
                  end
                  out_page          <= pop_page;
                  out_status        <= psta_pkg::ST_CHANGED;
                  out_fill_needed   <= 1'b1;
                  out_fill_material <= ent_mat;
                  in_use_r          <= in_use_r + 1'b1;
                  out_pages_in_use  <= in_use_r + 1'b1;
                  if (in_use_r + 1'b1 > hw_r) begin
                    hw_r                 <= in_use_r + 1'b1;
                    out_pages_high_water <= in_use_r + 1'b1;
                  end
                end
              end
              psta_pkg::KIND_SETSENT: begin
                if (ent_r != new_sent) begin
                  out_status <= psta_pkg::ST_CHANGED;
                  if (resident) begin
                    out_page <= ent_page;
                    if (free_cnt_r < POOL_N) begin
                      free_cnt_r <= free_cnt_r + 1'b1;
                    end
                    if (in_use_r != '0) begin
                      in_use_r         <= in_use_r - 1'b1;
                      out_pages_in_use <= in_use_r - 1'b1;
                    end
                  end
                end
              end
              psta_pkg::KIND_DEMOTE: begin
                if (resident) begin
                  out_status <= psta_pkg::ST_CHANGED;
                  out_page   <= ent_page;
                  if (ret_fill_r < POOL_N) begin
                    ret_fill_r <= ret_fill_r + 1'b1;
                  end
                  if (in_use_r != '0) begin
                    in_use_r         <= in_use_r - 1'b1;
                    out_pages_in_use <= in_use_r - 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
          out_valid <= 1'b1;
          st_r      <= S_OUT;
        end
        S_RET_RD: begin
          if (ret_fill_r == '0) begin
            st_r <= S_OUT;
          end else begin
            st_r <= S_RET_CHK;
          end
          out_status           <= (retired_r != '0) ? psta_pkg::ST_CHANGED :
                                                      psta_pkg::ST_NOCHANGE;
          out_page             <= '0;
          out_fill_needed      <= 1'b0;
          out_fill_material    <= '0;
          out_retired_count    <= retired_r;
          out_pages_in_use     <= in_use_r;
          out_pages_high_water <= hw_r;
          out_valid            <= (ret_fill_r == '0);
        end
        S_RET_CHK: begin
          // release head page if old enough, else finish
          if (age >= TW'(delay_r)) begin
            if (free_cnt_r < POOL_N) begin
              free_cnt_r <= free_cnt_r + 1'b1;
            end
            ret_head_r <= PA'((PCW)'(ret_head_r) + 1'b1 == POOL_N ? '0 :
                              (PCW)'(ret_head_r) + 1'b1);
            ret_fill_r <= ret_fill_r - 1'b1;
            retired_r  <= retired_r + 1'b1;
            st_r       <= S_RET_RD;
          end else begin
            out_valid <= 1'b1;
            st_r      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            st_r      <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/paged_slot_table_allocator.sv]
// Kinds 0 to 2, once a request is accepted into an idle executor, pass queue pop,
// slot table read and update in order; the result then holds until out_ready.
// Retire tick: S_RET_RD and S_RET_CHK repeat per released page until the queue is
// empty or its head page stays parked. A new request enters the executor only after
// the last result is accepted; the front queue holds two requests while it works.
// Reset: synchronous rst_n; a clearing pass then empties the slot table.
`default_nettype none
module paged_slot_table_allocator #(
  parameter int NUM_SLOTS     = psta_pkg::NUM_SLOTS_DEF,
  parameter int POOL_PAGES    = psta_pkg::POOL_PAGES_DEF,
  parameter int MATERIAL_BITS = psta_pkg::MATERIAL_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [psta_pkg::DELAY_W-1:0]     cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [psta_pkg::KIND_W-1:0]      in_kind,
  input  wire logic [psta_pkg::SLOT_W-1:0]      in_slot,
  input  wire logic [psta_pkg::MATIN_W-1:0]     in_material,
  input  wire logic [psta_pkg::TICK_W-1:0]      in_tick,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [psta_pkg::STATUS_W-1:0]         out_status,
  output logic [psta_pkg::PAGE_W-1:0]           out_page,
  output logic                                  out_fill_needed,
  output logic [psta_pkg::MATIN_W-1:0]          out_fill_material,
  output logic [psta_pkg::CNT_W-1:0]            out_retired_count,
  output logic [psta_pkg::CNT_W-1:0]            out_pages_in_use,
  output logic [psta_pkg::CNT_W-1:0]            out_pages_high_water
);

  logic           q_valid, q_pop;
  psta_pkg::req_t q_req;

  psta_front #(.NUM_SLOTS(NUM_SLOTS), .MATERIAL_BITS(MATERIAL_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_slot, .in_material, .in_tick,
    .q_valid, .q_pop, .q_req
  );

  psta_back #(.NUM_SLOTS(NUM_SLOTS), .POOL_PAGES(POOL_PAGES),
              .MATERIAL_BITS(MATERIAL_BITS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .q_valid, .q_pop, .q_req,
    .out_valid, .out_ready, .out_status, .out_page, .out_fill_needed,
    .out_fill_material, .out_retired_count, .out_pages_in_use, .out_pages_high_water
  );

endmodule
`default_nettype wire

[rtl/psta_checker.sv]
`default_nettype none
module psta_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [psta_pkg::STATUS_W-1:0]  out_status,
  input wire logic                           out_fill_needed,
  input wire logic [psta_pkg::CNT_W-1:0]     out_pages_in_use,
  input wire logic [psta_pkg::CNT_W-1:0]     out_pages_high_water
);

  // hold valid and the status while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");

  a_hw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pages_high_water >= out_pages_in_use)
    else $error("high water below in use");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_needed |-> out_status == psta_pkg::ST_CHANGED)
    else $error("fill without change");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= psta_pkg::ST_EXHAUSTED)
    else $error("bad status");

endmodule

bind paged_slot_table_allocator psta_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_status, .out_fill_needed,
  .out_pages_in_use, .out_pages_high_water
);
`default_nettype wire
